// File: hw/rtl/rne_pkg.sv
// Shared types, constants and symbol tables for the Roman numeral encoder.
`timescale 1ns / 1ps

package rne_pkg;

  localparam int unsigned VALUE_W    = 12;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned NUM_WEIGHTS = 13;
  localparam int unsigned IDX_W      = $clog2(NUM_WEIGHTS);
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 8;

  localparam logic [VALUE_W-1:0] SAT_LIMIT = 12'd3999;

  // ASCII codes of the Roman symbols
  localparam logic [CHAR_W-1:0] CH_NONE = 7'h00;
  localparam logic [CHAR_W-1:0] CH_C    = 7'h43;
  localparam logic [CHAR_W-1:0] CH_D    = 7'h44;
  localparam logic [CHAR_W-1:0] CH_I    = 7'h49;
  localparam logic [CHAR_W-1:0] CH_L    = 7'h4C;
  localparam logic [CHAR_W-1:0] CH_M    = 7'h4D;
  localparam logic [CHAR_W-1:0] CH_V    = 7'h56;
  localparam logic [CHAR_W-1:0] CH_X    = 7'h58;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture a new value and restart at the largest weight
    logic step;   // do one greedy step (emit a character or pass a weight)
  } rne_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_zero;    // value on the input port saturates to zero
    logic out_free;   // output register empty or being taken this cycle
    logic step_last;  // the current step emits the final character
  } rne_status_t;

  // Weight of each table entry, largest first
  function automatic logic [VALUE_W-1:0] weight_of(input logic [IDX_W-1:0] idx);
    logic [VALUE_W-1:0] w;
    case (idx)
      4'd0:    w = 12'd1000;
      4'd1:    w = 12'd900;
      4'd2:    w = 12'd500;
      4'd3:    w = 12'd400;
      4'd4:    w = 12'd100;
      4'd5:    w = 12'd90;
      4'd6:    w = 12'd50;
      4'd7:    w = 12'd40;
      4'd8:    w = 12'd10;
      4'd9:    w = 12'd9;
      4'd10:   w = 12'd5;
      4'd11:   w = 12'd4;
      default: w = 12'd1;
    endcase
    return w;
  endfunction

  // First symbol of each entry
  function automatic logic [CHAR_W-1:0] first_of(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      4'd0:    c = CH_M;
      4'd1:    c = CH_C;
      4'd2:    c = CH_D;
      4'd3:    c = CH_C;
      4'd4:    c = CH_C;
      4'd5:    c = CH_X;
      4'd6:    c = CH_L;
      4'd7:    c = CH_X;
      4'd8:    c = CH_X;
      4'd9:    c = CH_I;
      4'd10:   c = CH_V;
      4'd11:   c = CH_I;
      default: c = CH_I;
    endcase
    return c;
  endfunction

  // Second symbol of a subtractive pair, CH_NONE for single symbols
  function automatic logic [CHAR_W-1:0] second_of(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      4'd1:    c = CH_M;
      4'd3:    c = CH_D;
      4'd5:    c = CH_C;
      4'd7:    c = CH_L;
      4'd9:    c = CH_X;
      4'd11:   c = CH_V;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/rne_ctrl.sv
// Controller state machine: sequences load and greedy steps of one value.
`timescale 1ns / 1ps

module rne_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rne_pkg::rne_status_t status,
  output rne_pkg::rne_cmd_t    cmd
);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands from the state and the handshakes
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!status.in_zero) begin
            state_next = RUN;
          end
        end
      end
      RUN: begin
        if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.step_last) begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/rne_dp.sv
// Datapath: remaining value, weight index, pending pair symbol and output word.
`timescale 1ns / 1ps

module rne_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rne_pkg::VALUE_W-1:0]   in_value,
  input  rne_pkg::rne_cmd_t             cmd,
  output rne_pkg::rne_status_t          status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rne_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_last
);

  logic [rne_pkg::VALUE_W-1:0] remaining;
  logic [rne_pkg::VALUE_W-1:0] remaining_next;
  logic [rne_pkg::IDX_W-1:0]   idx;
  logic [rne_pkg::IDX_W-1:0]   idx_next;
  logic                        pend;
  logic                        pend_next;
  logic [rne_pkg::VALUE_W-1:0] sat_value;
  logic [rne_pkg::VALUE_W-1:0] weight;
  logic [rne_pkg::CHAR_W-1:0]  second;
  logic                        emit;
  logic [rne_pkg::CHAR_W-1:0]  emit_char;
  logic                        emit_last;

  // Saturate the incoming value
  assign sat_value = (in_value > rne_pkg::SAT_LIMIT) ? rne_pkg::SAT_LIMIT : in_value;

  assign weight = rne_pkg::weight_of(idx);
  assign second = rne_pkg::second_of(idx);

  // One greedy step: finish a pair, take the weight, or pass to the next one
  always_comb begin
    remaining_next = remaining;
    idx_next       = idx;
    pend_next      = pend;
    emit           = 1'b0;
    emit_char      = rne_pkg::first_of(idx);
    emit_last      = 1'b0;
    if (pend) begin
      emit      = 1'b1;
      emit_char = second;
      emit_last = (remaining == '0);
      pend_next = 1'b0;
    end else if (remaining >= weight) begin
      emit           = 1'b1;
      remaining_next = remaining - weight;
      if (second != rne_pkg::CH_NONE) begin
        pend_next = 1'b1;
      end else begin
        emit_last = (remaining_next == '0);
      end
    end else begin
      idx_next = idx + 1'b1;
    end
  end

  assign status.in_zero   = (sat_value == '0);
  assign status.out_free  = !out_valid || out_ready;
  assign status.step_last = emit && emit_last;

  // Advance the conversion registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      remaining <= sat_value;
      idx       <= '0;
      pend      <= 1'b0;
    end else if (cmd.step) begin
      remaining <= remaining_next;
      idx       <= idx_next;
      pend      <= pend_next;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      out_char <= emit_char;
      out_last <= emit_last;
    end
  end

endmodule

// File: hw/rtl/roman_numeral_encoder.sv
// Top level of the Roman numeral encoder: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Converts one unsigned value per input word into its Roman numeral, sent as
// a run of ASCII characters, one per output word, tlast on the final one.
// Input: s_tdata[11:0] holds the value; values above 3999 are taken as 3999.
// A value of zero produces no output word at all.
// Output: m_tdata[6:0] holds the character (C, D, I, L, M, V or X), m_tlast
// marks the end of the numeral.
// One value is converted at a time. s_tready is high only while no
// conversion is running; it rises again as soon as the final character has
// been moved into the output register, so the next value can be taken while
// that character still waits on m_tready.
// Steps: each greedy step of the controller either emits one character or
// passes over one of the thirteen weights. A value needs one step per
// character plus one per weight passed; each character enters the output
// register in the cycle after the step that makes it.
// When m_tready is low with a word waiting, the steps pause and nothing is
// lost. Synchronous reset drops any run in progress and empties the output.
module roman_numeral_encoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rne_pkg::S_TDATA_W-1:0]   s_tdata,   // [11:0] value, [15:12] zero
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rne_pkg::M_TDATA_W-1:0]   m_tdata,   // [6:0] character, [7] zero
  output logic                            m_tlast
);

  rne_pkg::rne_cmd_t            cmd;
  rne_pkg::rne_status_t         status;
  logic [rne_pkg::CHAR_W-1:0]   out_char;

  rne_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rne_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_value  (s_tdata[rne_pkg::VALUE_W-1:0]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (out_char),
    .out_last  (m_tlast)
  );

  // Pad the character to a whole byte
  assign m_tdata = {{(rne_pkg::M_TDATA_W - rne_pkg::CHAR_W){1'b0}}, out_char};

endmodule

// File: hw/rtl/rne_check.sv
// Port-level checker for the Roman numeral encoder, bound to the top level.
`timescale 1ns / 1ps

module rne_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [rne_pkg::S_TDATA_W-1:0]  s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [rne_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic                           m_tlast
);

  // Reset empties the output and reopens the input
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("output not empty or input closed after reset");

  // A stalled output word keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output word changed while stalled");

  // Only Roman symbols leave the block
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == 8'h43 || m_tdata == 8'h44 || m_tdata == 8'h49 ||
                  m_tdata == 8'h4C || m_tdata == 8'h4D || m_tdata == 8'h56 ||
                  m_tdata == 8'h58))
    else $error("illegal character on output");

  // A zero value starts no conversion
  a_zero_no_run: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tdata[11:0] == 12'd0) |=> s_tready)
    else $error("zero value started a conversion");

  // A nonzero value closes the input while it is converted
  a_busy_closed: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tdata[11:0] != 12'd0) |=> !s_tready)
    else $error("input open during a conversion");

endmodule

bind roman_numeral_encoder rne_check u_rne_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
